@@ rtl/apjq_pkg.sv @@
package apjq_pkg;

	localparam int ID_W     = 32;
	localparam int TIME_W   = 32;
	localparam int WAIT_W   = 24;
	localparam int COUNT_W  = 5;
	localparam int STATUS_W = 2;

	localparam logic [WAIT_W-1:0] MAX_WAIT_RESET = 24'd5000;

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_PUSHED  = 2'd0,
		ST_POPPED  = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_DROPPED = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_SCAN,
		S_MOVE_INIT,
		S_MOVE,
		S_DONE_PUSH,
		S_DONE_POP,
		S_DONE_EMPTY,
		S_DONE_FULL
	} state_t;

	typedef struct packed {
		logic    accept;
		logic    push_write;
		logic    occ_inc;
		logic    occ_dec;
		logic    scan_init;
		logic    scan_rd;
		logic    scan;
		logic    move_init;
		logic    move_rd;
		logic    move;
		logic    res_load;
		status_t res_status;
	} dp_cmd_t;

	typedef struct packed {
		logic pop;
		logic empty;
		logic full;
		logic more;
		logic rd_pend;
		logic hit;
		logic out_free;
	} dp_sts_t;

endpackage

@@ rtl/apjq_if.sv @@
interface job_in_if;
	logic                             valid;
	logic                             ready;
	logic                             opcode;
	logic signed [apjq_pkg::ID_W-1:0] job_id;
	logic                             job_priority;
	logic [apjq_pkg::TIME_W-1:0]      time_ms;

	modport source (output valid, opcode, job_id, job_priority, time_ms, input ready);
	modport sink (input valid, opcode, job_id, job_priority, time_ms, output ready);
endinterface

interface job_out_if;
	logic                              valid;
	logic                              ready;
	logic [apjq_pkg::STATUS_W-1:0]     status;
	logic signed [apjq_pkg::ID_W-1:0]  out_id;
	logic                              out_priority;
	logic                              aged;
	logic [apjq_pkg::COUNT_W-1:0]      entry_count;

	modport source (output valid, status, out_id, out_priority, aged, entry_count,
		input ready);
	modport sink (input valid, status, out_id, out_priority, aged, entry_count,
		output ready);
endinterface

@@ rtl/apjq_ram.sv @@
module apjq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/apjq_ctrl.sv @@
module apjq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  apjq_pkg::dp_sts_t sts,
	output apjq_pkg::dp_cmd_t cmd
);
	import apjq_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q) inside
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (!sts.pop) begin
					if (sts.full) begin
						state_d = S_DONE_FULL;
					end else begin
						cmd.push_write = 1'b1;
						cmd.occ_inc    = 1'b1;
						state_d        = S_DONE_PUSH;
					end
				end else if (sts.empty) begin
					state_d = S_DONE_EMPTY;
				end else begin
					cmd.scan_init = 1'b1;
					state_d       = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.hit) begin
					state_d = S_MOVE_INIT;
				end else if (sts.more) begin
					cmd.scan_rd = 1'b1;
				end else if (!sts.rd_pend) begin
					state_d = S_MOVE_INIT;
				end
			end
			S_MOVE_INIT: begin
				cmd.move_init = 1'b1;
				state_d       = S_MOVE;
			end
			S_MOVE: begin
				cmd.move = 1'b1;
				if (sts.more) begin
					cmd.move_rd = 1'b1;
				end else if (!sts.rd_pend) begin
					cmd.occ_dec = 1'b1;
					state_d     = S_DONE_POP;
				end
			end
			S_DONE_PUSH, S_DONE_POP, S_DONE_EMPTY, S_DONE_FULL: begin
				unique case (state_q)
					S_DONE_PUSH:  cmd.res_status = ST_PUSHED;
					S_DONE_POP:   cmd.res_status = ST_POPPED;
					S_DONE_EMPTY: cmd.res_status = ST_EMPTY;
					default:      cmd.res_status = ST_DROPPED;
				endcase
				if (sts.out_free) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/apjq_dp.sv @@
module apjq_dp #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  apjq_pkg::dp_cmd_t                   cmd,
	output apjq_pkg::dp_sts_t                   sts,
	input  logic                                cfg_wr_en,
	input  logic [apjq_pkg::WAIT_W-1:0]         cfg_wr_data,
	input  logic                                opcode,
	input  logic signed [apjq_pkg::ID_W-1:0]    job_id,
	input  logic                                job_priority,
	input  logic [apjq_pkg::TIME_W-1:0]         time_ms,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [apjq_pkg::STATUS_W-1:0]       out_status,
	output logic signed [apjq_pkg::ID_W-1:0]    out_id,
	output logic                                out_priority,
	output logic                                out_aged,
	output logic [apjq_pkg::COUNT_W-1:0]        out_entry_count
);
	import apjq_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int EW = 1 + TIME_W + ID_W;

	logic [WAIT_W-1:0] max_wait_q;
	logic [CW-1:0]     occ_q;
	logic [CW-1:0]     idx_q;
	logic              rd_pend_q;
	logic [AW-1:0]     rd_idx_q;
	logic [AW-1:0]     pick_q;
	logic              op_q;
	logic [ID_W-1:0]   id_q;
	logic              prio_q;
	logic [TIME_W-1:0] time_q;
	logic [ID_W-1:0]   res_id_q;
	logic              res_prio_q;
	logic              res_aged_q;
	logic              out_valid_q;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [EW-1:0]     ram_wdata;
	logic              ram_re;
	logic [EW-1:0]     ram_rdata;
	logic [ID_W-1:0]   r_id;
	logic [TIME_W-1:0] r_time;
	logic              r_prio;
	logic [TIME_W-1:0] wait_v;
	logic              ripe;
	logic              hit;

	assign r_id   = ram_rdata[ID_W-1:0];
	assign r_time = ram_rdata[ID_W +: TIME_W];
	assign r_prio = ram_rdata[EW-1];
	assign wait_v = time_q - r_time;
	assign ripe   = wait_v >= TIME_W'(max_wait_q);
	assign hit    = rd_pend_q && (r_prio || ripe);

	assign ram_re    = cmd.scan_rd || cmd.move_rd;
	assign ram_we    = cmd.push_write || (cmd.move && rd_pend_q);
	assign ram_waddr = cmd.push_write ? occ_q[AW-1:0] : rd_idx_q - AW'(1);
	assign ram_wdata = cmd.push_write ? {prio_q, time_q, id_q} : ram_rdata;

	apjq_ram #(
		.WIDTH(EW),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(idx_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	assign sts.pop      = (op_q == OP_POP);
	assign sts.empty    = (occ_q == '0);
	assign sts.full     = (occ_q == CW'(QUEUE_DEPTH));
	assign sts.more     = (idx_q < occ_q);
	assign sts.rd_pend  = rd_pend_q;
	assign sts.hit      = hit;
	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_wait_q  <= MAX_WAIT_RESET;
			occ_q       <= '0;
			rd_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				max_wait_q <= cfg_wr_data;
			end
			if (cmd.occ_inc) begin
				occ_q <= occ_q + CW'(1);
			end else if (cmd.occ_dec) begin
				occ_q <= occ_q - CW'(1);
			end
			rd_pend_q <= ram_re;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= opcode;
			id_q   <= job_id;
			prio_q <= job_priority;
			time_q <= time_ms;
		end
		if (cmd.scan_init) begin
			idx_q <= '0;
		end else if (cmd.move_init) begin
			idx_q <= CW'(pick_q) + CW'(1);
		end else if (ram_re) begin
			idx_q <= idx_q + CW'(1);
		end
		if (ram_re) begin
			rd_idx_q <= idx_q[AW-1:0];
		end
		if (cmd.scan && rd_pend_q && (rd_idx_q == '0 || hit)) begin
			res_id_q   <= r_id;
			res_prio_q <= r_prio;
			res_aged_q <= hit && !r_prio;
			pick_q     <= rd_idx_q;
		end
		if (cmd.res_load) begin
			out_status      <= cmd.res_status;
			out_id          <= (cmd.res_status == ST_POPPED) ? $signed(res_id_q) : '0;
			out_priority    <= (cmd.res_status == ST_POPPED) && res_prio_q;
			out_aged        <= (cmd.res_status == ST_POPPED) && res_aged_q;
			out_entry_count <= COUNT_W'(occ_q);
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ rtl/aging_priority_job_queue_top.sv @@
// Aging priority job queue: a bounded queue of up to QUEUE_DEPTH jobs.
// Transactions arrive on job_in with an opcode (push or pop), a job id, a
// priority and a time in milliseconds. Every accepted transaction yields
// exactly one result transaction on job_out with a status, the popped job's
// id and priority, an aged flag and the entry count after the operation.
// The wait limit for free jobs is written through cfg_wr_en and cfg_wr_data.
// The user must write it only while the queue is idle; the block itself
// does not enforce this. The block works on one transaction at a time.
// A push or a rejected operation goes from the decide state straight to its
// done state. A pop scans the entries one per cycle from the head until a
// job qualifies, or takes the head when none does, waits for the last read
// data, and then moves the entries behind the chosen one up one per cycle,
// all through the single read port of the entry memory.
// A new transaction is accepted the cycle after the result is loaded.
// The result sits in an output register; when job_out stalls, the block
// holds the next result until the register is free and does not accept a
// new transaction meanwhile. Reset empties the queue and sets the wait limit
// to 5000 ms; the entry memory itself is not cleared.
module aging_priority_job_queue_top #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [apjq_pkg::WAIT_W-1:0] cfg_wr_data,
	job_in_if.sink                      job_in,
	job_out_if.source                   job_out
);
	import apjq_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	apjq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(job_in.valid),
		.in_ready(job_in.ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	apjq_dp #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.opcode         (job_in.opcode),
		.job_id         (job_in.job_id),
		.job_priority   (job_in.job_priority),
		.time_ms        (job_in.time_ms),
		.out_ready      (job_out.ready),
		.out_valid      (job_out.valid),
		.out_status     (job_out.status),
		.out_id         (job_out.out_id),
		.out_priority   (job_out.out_priority),
		.out_aged       (job_out.aged),
		.out_entry_count(job_out.entry_count)
	);

endmodule

@@ rtl/apjq_chk.sv @@
module apjq_chk #(
	parameter int QUEUE_DEPTH = 16
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [apjq_pkg::STATUS_W-1:0] status,
	input logic [apjq_pkg::ID_W-1:0]    out_id,
	input logic                         out_priority,
	input logic                         aged,
	input logic [apjq_pkg::COUNT_W-1:0] entry_count
);
	import apjq_pkg::*;

	localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(QUEUE_DEPTH);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second transaction taken while one is in progress");

	a_no_job_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_POPPED |-> out_id == '0 && !out_priority && !aged)
		else $error("job fields set on a result without a popped job");

	a_aged_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && aged |-> status == ST_POPPED && !out_priority)
		else $error("aged flag on a premium job");

	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status != ST_EMPTY || entry_count == '0) &&
			(status != ST_DROPPED || entry_count == FULL_COUNT))
		else $error("entry count inconsistent with status");

endmodule

bind aging_priority_job_queue_top apjq_chk #(
	.QUEUE_DEPTH(QUEUE_DEPTH)
) u_apjq_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (job_in.valid),
	.in_ready    (job_in.ready),
	.out_valid   (job_out.valid),
	.out_ready   (job_out.ready),
	.status      (job_out.status),
	.out_id      (job_out.out_id),
	.out_priority(job_out.out_priority),
	.aged        (job_out.aged),
	.entry_count (job_out.entry_count)
);
